// ----- src/mbps_pkg.sv -----
package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int ADDR_W      = 64;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int MASK_W      = 16;
    localparam int LEN_REG_W   = 5;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO = 3'd0,
        CFG_PAT_HI = 3'd1,
        CFG_MASK   = 3'd2,
        CFG_LEN    = 3'd3,
        CFG_BASE   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] pat;
        logic [MAX_PATTERN-1:0]      wild;
        logic [LEN_W-1:0]            len;
        logic [ADDR_W-1:0]           base;
    } cfg_t;

endpackage

// ----- src/mbps_if.sv -----
interface mbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface mbps_result_if;
    import mbps_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_address;

    modport source (output valid, found, match_address, input ready);
    modport sink (input valid, found, match_address, output ready);
endinterface

// ----- src/mbps_cfg_regs.sv -----
module mbps_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]      cfg_data,
    output mbps_pkg::cfg_t                  cfg
);
    import mbps_pkg::*;

    logic [CFG_W-1:0]     pat_lo_reg, pat_hi_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [LEN_REG_W-1:0] len_reg;
    logic [ADDR_W-1:0]    base_reg;

    logic [2*CFG_W-1:0]          pat_all;
    logic [MAX_PATTERN-1:0][7:0] pat_w;
    logic [MAX_PATTERN-1:0]      wild_w;
    logic [LEN_W-1:0]            len_act;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            mask_reg   <= '0;
            len_reg    <= LEN_REG_W'(1);
            base_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PAT_LO: pat_lo_reg <= cfg_data;
                CFG_PAT_HI: pat_hi_reg <= cfg_data;
                CFG_MASK:   mask_reg   <= cfg_data[MASK_W-1:0];
                CFG_LEN:    len_reg    <= cfg_data[LEN_REG_W-1:0];
                CFG_BASE:   base_reg   <= cfg_data[ADDR_W-1:0];
                default:    ;
            endcase
        end
    end

    assign pat_all = {pat_hi_reg, pat_lo_reg};

    // only sixteen pattern bytes are programmable; the rest are fixed zero
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_pat
        if (k < 16)
        begin : g_prog
            assign pat_w[k]  = pat_all[8*k +: 8];
            assign wild_w[k] = mask_reg[k];
        end
        else
        begin : g_zero
            assign pat_w[k]  = 8'd0;
            assign wild_w[k] = 1'b0;
        end
    end

    always_comb
    begin
        if (len_reg == '0)
            len_act = LEN_W'(1);
        else if (int'(len_reg) > MAX_PATTERN)
            len_act = LEN_W'(MAX_PATTERN);
        else
            len_act = LEN_W'(len_reg);
    end

    assign cfg = '{pat: pat_w, wild: wild_w, len: len_act, base: base_reg};

endmodule

// ----- src/mbps_search.sv -----
module mbps_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    input  mbps_pkg::cfg_t                    cfg,
    output logic                              found,
    output logic [mbps_pkg::OFFSET_BITS-1:0]  offset
);
    import mbps_pkg::*;

    logic [MAX_PATTERN-1:0][7:0] window_reg, window_next;
    logic [OFFSET_BITS-1:0]      seen_reg, seen_next, seen_inc;
    logic [OFFSET_BITS-1:0]      off_reg, off_next, hit_off;
    logic                        match_reg, match_next;
    logic                        saturated, hit, cand;
    logic [MAX_PATTERN-1:0]      pos_ok;
    logic [LEN_W-1:0]            tap [MAX_PATTERN];

    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < MAX_PATTERN; i++)
            window_next[i] = window_reg[i-1];
    end

    // pattern byte j lines up with window entry len-1-j (entry 0 is newest)
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            tap[j]    = cfg.len - LEN_W'(j) - LEN_W'(1);
            pos_ok[j] = (LEN_W'(j) >= cfg.len) || cfg.wild[j] ||
                        (cfg.pat[j] == window_next[tap[j][IDX_W-1:0]]);
        end
    end

    assign hit       = &pos_ok;
    assign saturated = &seen_reg;
    assign seen_inc  = seen_reg + OFFSET_BITS'(1);
    assign hit_off   = seen_inc - OFFSET_BITS'(cfg.len);
    assign cand      = !saturated && !match_reg && hit &&
                       (seen_inc >= OFFSET_BITS'(cfg.len));

    assign found  = match_reg || cand;
    assign offset = cand ? hit_off : off_reg;

    always_comb
    begin
        seen_next  = seen_reg;
        match_next = match_reg;
        off_next   = off_reg;
        if (step)
        begin
            if (last_byte)
            begin
                seen_next  = '0;
                match_next = 1'b0;
                off_next   = '0;
            end
            else
            begin
                seen_next  = saturated ? seen_reg : seen_inc;
                match_next = found;
                off_next   = offset;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            match_reg <= 1'b0;
            off_reg   <= '0;
        end
        else
        begin
            seen_reg  <= seen_next;
            match_reg <= match_next;
            off_reg   <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            window_reg <= window_next;
    end

endmodule

// ----- src/masked_byte_pattern_search_core.sv -----
// Searches a byte stream for a pattern of up to 16 bytes with per-byte wildcards and
// returns one result per region, on the request marked last_byte: found plus
// base_address + offset of the first match (zero if none). Takes one byte per cycle
// sustained; after its last byte is accepted, a result passes through the input
// register, then the compare window and result register. The input side only
// holds off while a finished result waits in the output register and a further
// last byte is queued behind it. Configuration is written through cfg_we/cfg_index/
// cfg_data between regions.
module masked_byte_pattern_search_core (
    input  logic                            clk,
    input  logic                            rst_n,
    mbps_byte_if.sink                       bytes,
    mbps_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]      cfg_data
);
    import mbps_pkg::*;

    cfg_t                   cfg;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_last_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_go, in_take, load;
    logic                   hit_found;
    logic [OFFSET_BITS-1:0] hit_offset;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg;
    logic [ADDR_W-1:0]      out_addr_reg, out_addr_next;

    mbps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbps_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_go),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .cfg       (cfg),
        .found     (hit_found),
        .offset    (hit_offset)
    );

    assign s1_go       = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign bytes.ready = !s1_valid_reg || s1_go;
    assign in_take     = bytes.valid && bytes.ready;
    assign load        = s1_go && s1_last_reg;

    assign s1_valid_next  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign out_valid_next = load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    assign out_addr_next  = hit_found ? (cfg.base + ADDR_W'(hit_offset)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= bytes.data_byte;
            s1_last_reg <= bytes.last_byte;
        end
        if (load)
        begin
            out_found_reg <= hit_found;
            out_addr_reg  <= out_addr_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.found         = out_found_reg;
    assign result.match_address = out_addr_reg;

    a_no_addr_when_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.match_address == '0)
        else $error("match address nonzero without a match");

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> s1_valid_reg && s1_last_reg && out_valid_reg)
        else $error("input stalled without a pending result");

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result.valid)
        else $error("last byte produced no result");

endmodule
